// ===== sv/ipdfd_pkg.sv =====
package ipdfd_pkg;

  // Configuration register width and fixed result widths
  localparam int unsigned REG_W    = 24;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LEADER_MIN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEADER_MAX    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ONE_THRESHOLD = 2'd2;

  // Register reset values in ticks
  localparam logic [REG_W-1:0] LEADER_MIN_RST    = 24'd1060000;
  localparam logic [REG_W-1:0] LEADER_MAX_RST    = 24'd1070000;
  localparam logic [REG_W-1:0] ONE_THRESHOLD_RST = 24'd170000;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ABSORBED = 2'd0,
    ST_FRAME    = 2'd1,
    ST_REJECT   = 2'd2
  } status_e;

  // Timing windows as seen by the decoder
  typedef struct packed {
    logic [REG_W-1:0] leader_min;
    logic [REG_W-1:0] leader_max;
    logic [REG_W-1:0] one_threshold;
  } cfg_t;

  // One decoded result item
  typedef struct packed {
    status_e           status;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

// ===== sv/ipdfd_cfg_regs.sv =====
module ipdfd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ipdfd_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [ipdfd_pkg::REG_W-1:0]     cfg_wdata_i,
  output ipdfd_pkg::cfg_t                 cfg_o
);

  ipdfd_pkg::cfg_t cfg_q;

  // Register file; the unused index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_min    <= ipdfd_pkg::LEADER_MIN_RST;
      cfg_q.leader_max    <= ipdfd_pkg::LEADER_MAX_RST;
      cfg_q.one_threshold <= ipdfd_pkg::ONE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ipdfd_pkg::REG_LEADER_MIN:    cfg_q.leader_min    <= cfg_wdata_i;
        ipdfd_pkg::REG_LEADER_MAX:    cfg_q.leader_max    <= cfg_wdata_i;
        ipdfd_pkg::REG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ipdfd_frame_step.sv =====
module ipdfd_frame_step #(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned STAMP_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  input  ipdfd_pkg::cfg_t       cfg_i,
  output ipdfd_pkg::result_t    result_o
);

  localparam int unsigned CNT_W  = $clog2(FRAME_BITS + 2);
  localparam int unsigned CMP_W  = (STAMP_BITS > ipdfd_pkg::REG_W) ? STAMP_BITS
                                                                   : ipdfd_pkg::REG_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BITS + 1);

  logic [CNT_W-1:0]      edge_count_q, edge_count_d;
  logic [STAMP_BITS-1:0] last_stamp_q;
  logic [FRAME_BITS-1:0] bit_shift_q, bit_shift_d;
  logic [STAMP_BITS-1:0] interval;
  logic [CMP_W-1:0]      interval_x;
  logic                  leader_ok;
  logic                  bit_val;
  logic [FRAME_BITS-1:0] shift_nxt;
  logic [ipdfd_pkg::CODE_W-1:0] frame_code;

  // Interval wraps with the down-counter
  assign interval   = last_stamp_q - stamp_i;
  assign interval_x = CMP_W'(interval);
  assign leader_ok  = (interval_x > CMP_W'(cfg_i.leader_min)) &&
                      (interval_x < CMP_W'(cfg_i.leader_max));
  assign bit_val    = interval_x > CMP_W'(cfg_i.one_threshold);

  if (FRAME_BITS > 1) begin : g_shift
    assign shift_nxt = {bit_shift_q[FRAME_BITS-2:0], bit_val};
  end else begin : g_shift1
    assign shift_nxt = bit_val;
  end

  // Code carries the low bits of the frame
  if (FRAME_BITS >= ipdfd_pkg::CODE_W) begin : g_code_trunc
    assign frame_code = shift_nxt[ipdfd_pkg::CODE_W-1:0];
  end else begin : g_code_ext
    assign frame_code = {{(ipdfd_pkg::CODE_W - FRAME_BITS){1'b0}}, shift_nxt};
  end

  // Edge sequencing
  always_comb begin
    edge_count_d    = edge_count_q;
    bit_shift_d     = bit_shift_q;
    result_o.status = ipdfd_pkg::ST_ABSORBED;
    result_o.code   = '0;
    priority if (edge_count_q == '0) begin
      edge_count_d = CNT_W'(1);
      bit_shift_d  = '0;
    end else if (edge_count_q == CNT_W'(1)) begin
      if (leader_ok) begin
        edge_count_d = CNT_W'(2);
        bit_shift_d  = '0;
      end else begin
        edge_count_d    = '0;
        result_o.status = ipdfd_pkg::ST_REJECT;
      end
    end else if (edge_count_q == LAST_CNT) begin
      // final bit closes the frame
      edge_count_d    = '0;
      bit_shift_d     = '0;
      result_o.status = ipdfd_pkg::ST_FRAME;
      result_o.code   = frame_code;
    end else begin
      edge_count_d = edge_count_q + CNT_W'(1);
      bit_shift_d  = shift_nxt;
    end
  end

  // Decoder state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_count_q <= '0;
      last_stamp_q <= '0;
      bit_shift_q  <= '0;
    end else if (step_i) begin
      edge_count_q <= edge_count_d;
      last_stamp_q <= stamp_i;
      bit_shift_q  <= bit_shift_d;
    end
  end

endmodule

// ===== sv/ir_pulse_distance_frame_decoder_top.sv =====
// Pulse-distance IR frame decoder.
// Slave stream: one item per falling edge of the IR receiver, tdata carries
// the down-counter stamp taken at that edge. Master stream: exactly one
// result item per input item, tdata = {code, status}. Status is absorbed,
// frame complete (code valid) or leader rejected.
// Configuration: write enable, index and data; 0 leader_min, 1 leader_max,
// 2 one_threshold. Write only while no item is in flight.
// The input register captures an item at the accepting edge, and the result
// register takes it from the input register once the result register is free.
// Throughput: one item per cycle while the master side takes results, set
// by the single subtract/compare/shift stage between the two registers.
// Reset clears the edge counter, last stamp, bit buffer and both pipeline
// stages, and loads the default timing windows.
// When the master side stalls, the result register holds its item and the
// input register can still take one more item; s_axis_tready then drops
// until the result is taken.
module ir_pulse_distance_frame_decoder_top #(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned STAMP_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ipdfd_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [ipdfd_pkg::REG_W-1:0]   cfg_wdata_i,
  // edge stamps in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((STAMP_BITS+7)/8)*8-1:0] s_axis_tdata,  // [STAMP_BITS-1:0] edge_stamp
  // results out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata   // [1:0] status, [33:2] code
);

  localparam int unsigned RES_W = ipdfd_pkg::STATUS_W + ipdfd_pkg::CODE_W;

  ipdfd_pkg::cfg_t       cfg;
  ipdfd_pkg::result_t    step_res;
  logic                  in_valid_q;
  logic [STAMP_BITS-1:0] in_stamp_q;
  logic                  out_valid_q;
  ipdfd_pkg::result_t    out_res_q;
  logic                  advance;
  logic                  in_take;

  ipdfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: move input stage to result register when it is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_stamp_q <= s_axis_tdata[STAMP_BITS-1:0];
    end
  end

  ipdfd_frame_step #(
    .FRAME_BITS (FRAME_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .stamp_i  (in_stamp_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(40 - RES_W){1'b0}}, out_res_q.code, out_res_q.status};

endmodule

// ===== sim/testbench.sv =====
module testbench;

  localparam int unsigned STAMP_W     = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  // index past the register list, writes to it must be dropped
  localparam logic [ipdfd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ipdfd_pkg::IDX_W-1:0]   cfg_index_i;
  logic [ipdfd_pkg::REG_W-1:0]   cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [STAMP_W-1:0]            s_axis_tdata;   // [23:0] edge_stamp
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [39:0]                   m_axis_tdata;   // [1:0] status, [33:2] code

  ir_pulse_distance_frame_decoder_top #(
    .FRAME_BITS(32),
    .STAMP_BITS(STAMP_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Decoder model state and timing windows
  ipdfd_pkg::cfg_t                model_cfg;
  logic [5:0]                     frame_edges;
  logic [STAMP_W-1:0]             prev_stamp;
  logic [ipdfd_pkg::CODE_W-1:0]   frame_bits;
  ipdfd_pkg::result_t             expected_results[$];

  logic [STAMP_W-1:0] now_stamp;      // last stamp sent, the generator counts down from it
  int unsigned        items_sent;
  int unsigned        results_seen;
  int unsigned        mismatches;
  int unsigned        cycle_count;
  bit                 send_idle;
  bit                 recv_idle;

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("ERROR result %0d %s: got 0x%h, expected 0x%h", results_seen, what, got, want);
  endtask

  // Expected result of one accepted edge; updates the model state
  task automatic predict_edge(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] interval;
    ipdfd_pkg::result_t res;
    interval   = prev_stamp - stamp;
    res.status = ipdfd_pkg::ST_ABSORBED;
    res.code   = '0;
    if (frame_edges == 6'd0) begin
      frame_edges = 6'd1;
      frame_bits  = '0;
    end else if (frame_edges == 6'd1) begin
      // leader window, both bounds exclusive
      if (interval > model_cfg.leader_min && interval < model_cfg.leader_max) begin
        frame_edges = 6'd2;
        frame_bits  = '0;
      end else begin
        frame_edges = 6'd0;
        res.status  = ipdfd_pkg::ST_REJECT;
      end
    end else begin
      frame_bits  = {frame_bits[ipdfd_pkg::CODE_W-2:0], interval > model_cfg.one_threshold};
      frame_edges = frame_edges + 6'd1;
      if (frame_edges >= 6'd34) begin
        res.status  = ipdfd_pkg::ST_FRAME;
        res.code    = frame_bits;
        frame_edges = 6'd0;
        frame_bits  = '0;
      end
    end
    prev_stamp = stamp;
    expected_results.push_back(res);
  endtask

  // Send one edge stamp; returns at the falling edge after acceptance
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_edge(stamp);
    now_stamp = stamp;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic step_edge(input logic [STAMP_W-1:0] interval);
    logic [STAMP_W-1:0] nxt;
    nxt = now_stamp - interval;
    send_stamp(nxt);
  endtask

  // Wait until every expected result has come, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ipdfd_pkg::IDX_W-1:0] idx,
                           input logic [ipdfd_pkg::REG_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      ipdfd_pkg::REG_LEADER_MIN:    model_cfg.leader_min    = value;
      ipdfd_pkg::REG_LEADER_MAX:    model_cfg.leader_max    = value;
      ipdfd_pkg::REG_ONE_THRESHOLD: model_cfg.one_threshold = value;
      default: ;
    endcase
  endtask

  task automatic set_windows(input logic [ipdfd_pkg::REG_W-1:0] lmin,
                             input logic [ipdfd_pkg::REG_W-1:0] lmax,
                             input logic [ipdfd_pkg::REG_W-1:0] thr);
    drain();
    write_reg(ipdfd_pkg::REG_LEADER_MIN, lmin);
    write_reg(ipdfd_pkg::REG_LEADER_MAX, lmax);
    write_reg(ipdfd_pkg::REG_ONE_THRESHOLD, thr);
  endtask

  // Interval for one data bit; exact picks the values right at the threshold
  function automatic logic [STAMP_W-1:0] bit_interval(input bit one, input bit exact);
    int unsigned thr;
    int unsigned hi;
    thr = model_cfg.one_threshold;
    if (one) begin
      if (thr == STAMP_MAX) return STAMP_W'($urandom);
      if (exact || $urandom_range(0, 7) == 0) return STAMP_W'(thr + 1);
      hi = 2 * thr + 1000;
      if (hi > STAMP_MAX) hi = STAMP_MAX;
      return STAMP_W'($urandom_range(thr + 1, hi));
    end
    if (exact || $urandom_range(0, 7) == 0) return STAMP_W'(thr);
    return STAMP_W'($urandom_range(0, thr));
  endfunction

  function automatic logic [STAMP_W-1:0] lead_in_window();
    if (model_cfg.leader_max > model_cfg.leader_min + 1)
      return STAMP_W'($urandom_range(model_cfg.leader_min + 1, model_cfg.leader_max - 1));
    return STAMP_W'($urandom);
  endfunction

  // First edge, leader and nbits data edges; resyncs the decoder first
  task automatic send_frame(input logic [STAMP_W-1:0] first,
                            input logic [ipdfd_pkg::CODE_W-1:0] code,
                            input logic [STAMP_W-1:0] lead, input bit exact, input int nbits);
    while (frame_edges != 6'd0) step_edge(STAMP_W'($urandom));
    send_stamp(first);
    step_edge(lead);
    for (int i = 0; i < nbits; i++)
      step_edge(bit_interval(code[ipdfd_pkg::CODE_W-1-i], exact));
  endtask

  // Result checker
  always @(posedge clk_i) begin : result_check
    ipdfd_pkg::result_t             want;
    logic [ipdfd_pkg::STATUS_W-1:0] got_status;
    logic [ipdfd_pkg::CODE_W-1:0]   got_code;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[1:0];
      got_code   = m_axis_tdata[33:2];
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata[33:0]), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got_status !== want.status)
          report_mismatch("status", 32'(got_status), 32'(want.status));
        if (got_code !== want.code) report_mismatch("code", got_code, want.code);
      end
    end
  end

  // Result side ready, random stall per item
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Leaders on and outside the window bounds, with stamp wrap
  task automatic test_leader_bounds();
    set_windows(ipdfd_pkg::LEADER_MIN_RST, ipdfd_pkg::LEADER_MAX_RST,
                ipdfd_pkg::ONE_THRESHOLD_RST);
    send_stamp(STAMP_MAX);
    step_edge(model_cfg.leader_min);
    send_stamp('0);
    step_edge(model_cfg.leader_max);
    send_stamp(STAMP_W'($urandom));
    step_edge('0);
    send_stamp(STAMP_W'($urandom));
    step_edge(STAMP_MAX);
  endtask

  // Full frames with intervals right at the bit threshold
  task automatic test_exact_frames();
    send_frame(STAMP_W'(5000), 32'hFFFF_FFFF, model_cfg.leader_min + 24'd1, 1'b1, 32);
    send_frame(STAMP_MAX, 32'h0000_0000, model_cfg.leader_max - 24'd1, 1'b1, 32);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_frame('0, 32'h5A3C_96E1, lead_in_window(), 1'b0, 32);
  endtask

  // Register extremes and writes to an index past the list
  task automatic test_register_extremes();
    drain();
    write_reg(REG_UNUSED, STAMP_MAX);
    write_reg(REG_UNUSED, '0);
    send_frame(STAMP_W'($urandom), $urandom, lead_in_window(), 1'b0, 32);
    // widest window, every nonzero interval is a one
    set_windows('0, STAMP_MAX, '0);
    send_frame(STAMP_W'($urandom), $urandom, lead_in_window(), 1'b0, 32);
    send_frame(STAMP_W'($urandom), 32'h0F0F_3355, lead_in_window(), 1'b1, 32);
    // inverted window rejects all leaders, threshold at top decodes only zeros
    set_windows(STAMP_MAX, '0, STAMP_MAX);
    repeat (3) begin
      send_stamp(STAMP_W'($urandom));
      step_edge(STAMP_W'($urandom));
    end
    // empty window
    set_windows(24'h400000, 24'h400000, 24'h800000);
    send_frame(STAMP_W'($urandom), $urandom, 24'h400000, 1'b0, 32);
    // single accepted leader value
    set_windows(24'h123456, 24'h123458, STAMP_MAX);
    send_frame(STAMP_W'($urandom), $urandom, 24'h123457, 1'b0, 32);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned pick;
    logic [ipdfd_pkg::REG_W-1:0] lmin;
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: set_windows(ipdfd_pkg::LEADER_MIN_RST, ipdfd_pkg::LEADER_MAX_RST,
                       ipdfd_pkg::ONE_THRESHOLD_RST);
        1: begin
          lmin = ipdfd_pkg::REG_W'($urandom_range(0, 24'h7FFFFF));
          set_windows(lmin, lmin + ipdfd_pkg::REG_W'($urandom_range(2, 24'h0FFFFF)),
                      ipdfd_pkg::REG_W'($urandom_range(0, 24'h3FFFFF)));
        end
        2: begin
          lmin = ipdfd_pkg::REG_W'($urandom_range(0, STAMP_MAX - 2));
          set_windows(lmin, lmin + 24'd2, ipdfd_pkg::REG_W'($urandom));
        end
        default: set_windows(ipdfd_pkg::REG_W'($urandom_range(0, 24'h7FFFFF)),
                             ipdfd_pkg::REG_W'($urandom_range(24'h800000, STAMP_MAX)),
                             ipdfd_pkg::REG_W'($urandom));
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 55) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_frame(STAMP_W'($urandom), $urandom, lead_in_window(), 1'b0, 32);
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 5)) send_stamp(STAMP_W'($urandom));
        end else if (pick == 8) begin
          // frame cut short, the next frame resyncs
          send_frame(STAMP_W'($urandom), $urandom, lead_in_window(), 1'b0,
                     $urandom_range(0, 31));
        end else begin
          send_stamp(STAMP_W'($urandom));
          step_edge(STAMP_W'($urandom));
        end
        // hold the sender until the pipeline is empty now and then
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = ipdfd_pkg::REG_LEADER_MIN;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    cycle_count   = 0;
    now_stamp     = '0;
    model_cfg.leader_min    = ipdfd_pkg::LEADER_MIN_RST;
    model_cfg.leader_max    = ipdfd_pkg::LEADER_MAX_RST;
    model_cfg.one_threshold = ipdfd_pkg::ONE_THRESHOLD_RST;
    frame_edges   = '0;
    prev_stamp    = '0;
    frame_bits    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_leader_bounds();
    test_exact_frames();
    test_register_extremes();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ipdfd_pkg.sv
sv/ipdfd_cfg_regs.sv
sv/ipdfd_frame_step.sv
sv/ir_pulse_distance_frame_decoder_top.sv
sim/testbench.sv
